>>> hw/rtl/texture_mip_layout_offset_unit_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef TEXTURE_MIP_LAYOUT_OFFSET_UNIT_MACROS_SVH
`define TEXTURE_MIP_LAYOUT_OFFSET_UNIT_MACROS_SVH

// Same-cycle implication.
`define TMLO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmlo: same-cycle check failed");

// Next-cycle implication.
`define TMLO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmlo: next-cycle check failed");

`endif

>>> hw/rtl/tmlo_pkg.sv
package tmlo_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int CFG_DIM_W    = 16;
	localparam int BLK_W        = 5;
	localparam int MUL_A_W      = 48;
	localparam int MUL_B_W      = 16;
	localparam int PROD_W       = MUL_A_W + MUL_B_W;
	localparam int BYTE_W       = 64;
	localparam int MIP_W        = 6;
	localparam int LAYER_W      = 16;
	localparam int MAXMIP_W     = 5;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 248;
	localparam int APB_AW       = 5;
	localparam int APB_DW       = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_BASE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BASE_DEPTH  = 3'd2;
	localparam logic [2:0] REG_LAYER_COUNT = 3'd3;
	localparam logic [2:0] REG_BLOCK_COMP  = 3'd4;
	localparam logic [2:0] REG_BLOCK_W     = 3'd5;
	localparam logic [2:0] REG_BLOCK_H     = 3'd6;
	localparam logic [2:0] REG_UNIT_BYTES  = 3'd7;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] base_width;
		logic [CFG_DIM_W-1:0] base_height;
		logic [CFG_DIM_W-1:0] base_depth;
		logic [LAYER_W-1:0]   layer_count;
		logic                 block_compressed;
		logic [BLK_W-1:0]     block_width;
		logic [BLK_W-1:0]     block_height;
		logic [BLK_W-1:0]     unit_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [LAYER_W-1:0] layer_index;
		logic [MIP_W-1:0]   mip_index;
	} in_t;

	typedef struct packed {
		logic [2:0]          pad;
		logic [MAXMIP_W-1:0] max_mips;
		logic [BYTE_W-1:0]   layer_offset;
		logic [BYTE_W-1:0]   mip_offset;
		logic [BYTE_W-1:0]   image_bytes;
		logic [15:0]         mip_depth;
		logic [15:0]         mip_height;
		logic [15:0]         mip_width;
	} out_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_START,
		OP_LEVEL,
		OP_DIV_LD_X,
		OP_DIV_STEP,
		OP_DIV_LD_Y,
		OP_DIV_SV_Y,
		OP_MUL_XY,
		OP_MUL_D,
		OP_MUL_U,
		OP_ACC,
		OP_MUL_SLO,
		OP_MUL_SHI,
		OP_MUL_ILO,
		OP_MUL_IHI,
		OP_ADD_LHI,
		OP_ADD_MOFF,
		OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		logic empty;
		logic compressed;
		logic at_mip;
		logic div_last;
	} stat_t;

endpackage

>>> hw/rtl/tmlo_dpath.sv
module tmlo_dpath #(
	parameter int DIM_BITS = tmlo_pkg::DIM_BITS_DEF
) (
	input  logic                             clk,
	input  tmlo_pkg::cfg_t                   cfg,
	input  tmlo_pkg::in_t                    in_data,
	input  tmlo_pkg::op_t                    op,
	output tmlo_pkg::stat_t                  stat,
	output logic [tmlo_pkg::OUT_TDATA_W-1:0] out_data
);
	import tmlo_pkg::*;

	localparam int DW    = (DIM_BITS < CFG_DIM_W) ? DIM_BITS : CFG_DIM_W;
	localparam int QW    = DW + 1;
	localparam int CNT_W = $clog2(QW + 1);

	logic [MIP_W-1:0]    mip_q, level_q;
	logic [LAYER_W-1:0]  layer_q;
	logic                empty_q;
	logic [MAXMIP_W-1:0] mm_q;
	logic [DW-1:0]       w_q, h_q, d_q, x_q, y_q;
	logic [QW-1:0]       div_q;
	logic [BLK_W-1:0]    rem_q, dvs_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [BYTE_W-1:0]   sum_q, img_q, moff_q, loff_q;
	out_t                out_q;

	logic [DW-1:0]       bw, bh, bd, sh_w, sh_h, sh_d, lvl_w, lvl_h, lvl_d, biggest;
	logic                cfg_empty;
	logic [MAXMIP_W-1:0] mm_d;
	logic [BLK_W-1:0]    dvs_x, dvs_y;
	logic [BLK_W:0]      trial;
	logic                fits;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   prod_d;
	out_t                res;

	assign bw = cfg.base_width[DW-1:0];
	assign bh = cfg.base_height[DW-1:0];
	assign bd = cfg.base_depth[DW-1:0];
	assign cfg_empty = (bw == '0) || (bh == '0) || (bd == '0);

	assign sh_w  = bw >> level_q;
	assign sh_h  = bh >> level_q;
	assign sh_d  = bd >> level_q;
	assign lvl_w = (sh_w == '0) ? DW'(1) : sh_w;
	assign lvl_h = (sh_h == '0) ? DW'(1) : sh_h;
	assign lvl_d = (sh_d == '0) ? DW'(1) : sh_d;

	always_comb begin
		biggest = bw;
		if (bh > biggest) biggest = bh;
		if (bd > biggest) biggest = bd;
		mm_d = '0;
		for (int i = 0; i < DW; i++) begin
			if (biggest[i]) mm_d = MAXMIP_W'(i + 1);
		end
	end

	// block size of zero counts as one
	assign dvs_x = (cfg.block_width == '0) ? BLK_W'(1) : cfg.block_width;
	assign dvs_y = (cfg.block_height == '0) ? BLK_W'(1) : cfg.block_height;

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, div_q[QW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_MUL_XY:  begin mul_a = MUL_A_W'(x_q);          mul_b = MUL_B_W'(y_q); end
			OP_MUL_D:   begin mul_a = prod_q[MUL_A_W-1:0];    mul_b = MUL_B_W'(d_q); end
			OP_MUL_U:   begin mul_a = prod_q[MUL_A_W-1:0];    mul_b = MUL_B_W'(cfg.unit_bytes); end
			OP_MUL_SLO: begin mul_a = MUL_A_W'(sum_q[31:0]);  mul_b = cfg.layer_count; end
			OP_MUL_SHI: begin mul_a = MUL_A_W'(sum_q[63:32]); mul_b = cfg.layer_count; end
			OP_MUL_ILO: begin mul_a = MUL_A_W'(img_q[31:0]);  mul_b = layer_q; end
			OP_MUL_IHI: begin mul_a = MUL_A_W'(img_q[63:32]); mul_b = layer_q; end
			default: begin end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	always_comb begin
		res = '0;
		if (!empty_q) begin
			res.mip_width    = 16'(w_q);
			res.mip_height   = 16'(h_q);
			res.mip_depth    = 16'(d_q);
			res.image_bytes  = img_q;
			res.mip_offset   = moff_q;
			res.layer_offset = (mip_q == '0 && cfg.layer_count == '0) ? '0 : loff_q;
			res.max_mips     = mm_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_START: begin
				mip_q   <= in_data.mip_index;
				layer_q <= in_data.layer_index;
				level_q <= '0;
				sum_q   <= '0;
				empty_q <= cfg_empty;
				mm_q    <= mm_d;
			end
			OP_LEVEL: begin
				w_q <= lvl_w;
				h_q <= lvl_h;
				d_q <= lvl_d;
				x_q <= lvl_w;
				y_q <= lvl_h;
			end
			OP_DIV_LD_X: begin
				div_q <= QW'(w_q) + QW'(dvs_x) - QW'(1);
				dvs_q <= dvs_x;
				rem_q <= '0;
				cnt_q <= CNT_W'(QW);
			end
			OP_DIV_STEP: begin
				rem_q <= fits ? BLK_W'(trial - {1'b0, dvs_q}) : trial[BLK_W-1:0];
				div_q <= {div_q[QW-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_DIV_LD_Y: begin
				x_q   <= div_q[DW-1:0];
				div_q <= QW'(h_q) + QW'(dvs_y) - QW'(1);
				dvs_q <= dvs_y;
				rem_q <= '0;
				cnt_q <= CNT_W'(QW);
			end
			OP_DIV_SV_Y: y_q <= div_q[DW-1:0];
			OP_MUL_XY, OP_MUL_D, OP_MUL_U, OP_MUL_SLO: prod_q <= prod_d;
			OP_ACC: begin
				if (level_q == mip_q) begin
					img_q <= prod_q;
				end else begin
					sum_q   <= sum_q + prod_q;
					level_q <= level_q + MIP_W'(1);
				end
			end
			OP_MUL_SHI: begin
				moff_q <= prod_q;
				prod_q <= prod_d;
			end
			OP_MUL_ILO: begin
				moff_q <= moff_q + {prod_q[31:0], 32'h0};
				prod_q <= prod_d;
			end
			OP_MUL_IHI: begin
				loff_q <= prod_q;
				prod_q <= prod_d;
			end
			OP_ADD_LHI:  loff_q <= loff_q + {prod_q[31:0], 32'h0};
			OP_ADD_MOFF: loff_q <= loff_q + moff_q;
			OP_LOAD_OUT: out_q  <= res;
			default: begin end
		endcase
	end

	assign stat.empty      = cfg_empty;
	assign stat.compressed = cfg.block_compressed;
	assign stat.at_mip     = (level_q == mip_q);
	assign stat.div_last   = (cnt_q == CNT_W'(1));
	assign out_data        = out_q;

endmodule

>>> hw/rtl/tmlo_ctrl.sv
module tmlo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tmlo_pkg::stat_t stat,
	output tmlo_pkg::op_t   op
);
	import tmlo_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_LEVEL   = 18'h00002,
		S_DIVX_LD = 18'h00004,
		S_DIVX    = 18'h00008,
		S_DIVY_LD = 18'h00010,
		S_DIVY    = 18'h00020,
		S_DIVY_SV = 18'h00040,
		S_MXY     = 18'h00080,
		S_MD      = 18'h00100,
		S_MU      = 18'h00200,
		S_ACC     = 18'h00400,
		S_MSLO    = 18'h00800,
		S_MSHI    = 18'h01000,
		S_MILO    = 18'h02000,
		S_MIHI    = 18'h04000,
		S_LHI     = 18'h08000,
		S_FIN     = 18'h10000,
		S_DONE    = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_START;
					state_d = stat.empty ? S_DONE : S_LEVEL;
				end
			end
			S_LEVEL: begin
				op      = OP_LEVEL;
				state_d = stat.compressed ? S_DIVX_LD : S_MXY;
			end
			S_DIVX_LD: begin
				op      = OP_DIV_LD_X;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				op = OP_DIV_STEP;
				if (stat.div_last) state_d = S_DIVY_LD;
			end
			S_DIVY_LD: begin
				op      = OP_DIV_LD_Y;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				op = OP_DIV_STEP;
				if (stat.div_last) state_d = S_DIVY_SV;
			end
			S_DIVY_SV: begin
				op      = OP_DIV_SV_Y;
				state_d = S_MXY;
			end
			S_MXY: begin
				op      = OP_MUL_XY;
				state_d = S_MD;
			end
			S_MD: begin
				op      = OP_MUL_D;
				state_d = S_MU;
			end
			S_MU: begin
				op      = OP_MUL_U;
				state_d = S_ACC;
			end
			S_ACC: begin
				op      = OP_ACC;
				state_d = stat.at_mip ? S_MSLO : S_LEVEL;
			end
			S_MSLO: begin
				op      = OP_MUL_SLO;
				state_d = S_MSHI;
			end
			S_MSHI: begin
				op      = OP_MUL_SHI;
				state_d = S_MILO;
			end
			S_MILO: begin
				op      = OP_MUL_ILO;
				state_d = S_MIHI;
			end
			S_MIHI: begin
				op      = OP_MUL_IHI;
				state_d = S_LHI;
			end
			S_LHI: begin
				op      = OP_ADD_LHI;
				state_d = S_FIN;
			end
			S_FIN: begin
				op      = OP_ADD_MOFF;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					op      = OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD_OUT) out_valid_q <= 1'b1;
			else if (out_ready)    out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/texture_mip_layout_offset_unit.sv
// Texture mip chain layout unit.
// Set the level-zero size, layer count and format over the APB port, then
// send queries on the s_axis stream (mip level and array layer). Each query
// returns one result on m_axis: the mip's size, one layer's byte size, the
// byte offset of the mip, the byte offset of the layer and the mip count.
// One query is worked at a time. Every level up to the requested one is
// sized in turn on a single shared 48x16 multiplier; block formats also run
// two bit-serial divides of min(DIM_BITS,16)+1 steps (17 by default) per level.
// A texture with an empty dimension skips every level and answers with zeros.
// The next query is taken as soon as a result sits in the output register;
// while the receiver stalls, a finished result waits in the datapath and
// no further query is accepted. Reset sets the registers to their defaults
// (1x1x1, one layer, 4 bytes per pixel) and empties both channels.
`include "texture_mip_layout_offset_unit_macros.svh"

module texture_mip_layout_offset_unit #(
	parameter int DIM_BITS = tmlo_pkg::DIM_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tmlo_pkg::APB_AW-1:0]      paddr,
	input  logic [tmlo_pkg::APB_DW-1:0]      pwdata,
	output logic [tmlo_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [5:0] mip_index, [21:6] layer_index, [23:22] zero
	input  logic [tmlo_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] mip_width, [31:16] mip_height, [47:32] mip_depth,
	// [111:48] image_bytes, [175:112] mip_offset, [239:176] layer_offset,
	// [244:240] max_mips, [247:245] zero
	output logic [tmlo_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tmlo_pkg::*;

	localparam int DW = (DIM_BITS < CFG_DIM_W) ? DIM_BITS : CFG_DIM_W;

	logic [DW-1:0]      base_width_q, base_height_q, base_depth_q;
	logic [LAYER_W-1:0] layer_count_q;
	logic               block_comp_q;
	logic [BLK_W-1:0]   block_w_q, block_h_q, unit_bytes_q;
	logic               wr_en;
	logic [2:0]         reg_sel;
	cfg_t               cfg;
	op_t                op;
	stat_t              stat;
	out_t               out_view;
	logic               dims_nonzero;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q  <= DW'(1);
			base_height_q <= DW'(1);
			base_depth_q  <= DW'(1);
			layer_count_q <= LAYER_W'(1);
			block_comp_q  <= 1'b0;
			block_w_q     <= BLK_W'(4);
			block_h_q     <= BLK_W'(4);
			unit_bytes_q  <= BLK_W'(4);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BASE_WIDTH:  base_width_q  <= pwdata[DW-1:0];
				REG_BASE_HEIGHT: base_height_q <= pwdata[DW-1:0];
				REG_BASE_DEPTH:  base_depth_q  <= pwdata[DW-1:0];
				REG_LAYER_COUNT: layer_count_q <= pwdata[LAYER_W-1:0];
				REG_BLOCK_COMP:  block_comp_q  <= pwdata[0];
				REG_BLOCK_W:     block_w_q     <= pwdata[BLK_W-1:0];
				REG_BLOCK_H:     block_h_q     <= pwdata[BLK_W-1:0];
				REG_UNIT_BYTES:  unit_bytes_q  <= pwdata[BLK_W-1:0];
				default: begin end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BASE_WIDTH:  prdata = APB_DW'(base_width_q);
			REG_BASE_HEIGHT: prdata = APB_DW'(base_height_q);
			REG_BASE_DEPTH:  prdata = APB_DW'(base_depth_q);
			REG_LAYER_COUNT: prdata = APB_DW'(layer_count_q);
			REG_BLOCK_COMP:  prdata = APB_DW'(block_comp_q);
			REG_BLOCK_W:     prdata = APB_DW'(block_w_q);
			REG_BLOCK_H:     prdata = APB_DW'(block_h_q);
			REG_UNIT_BYTES:  prdata = APB_DW'(unit_bytes_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.base_width       = CFG_DIM_W'(base_width_q);
	assign cfg.base_height      = CFG_DIM_W'(base_height_q);
	assign cfg.base_depth       = CFG_DIM_W'(base_depth_q);
	assign cfg.layer_count      = layer_count_q;
	assign cfg.block_compressed = block_comp_q;
	assign cfg.block_width      = block_w_q;
	assign cfg.block_height     = block_h_q;
	assign cfg.unit_bytes       = unit_bytes_q;

	tmlo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.op        (op)
	);

	tmlo_dpath #(
		.DIM_BITS (DIM_BITS)
	) u_dpath (
		.clk      (clk),
		.cfg      (cfg),
		.in_data  (s_axis_tdata),
		.op       (op),
		.stat     (stat),
		.out_data (m_axis_tdata)
	);

	assign out_view     = m_axis_tdata;
	assign dims_nonzero = out_view.mip_width != '0 && out_view.mip_height != '0 &&
		out_view.mip_depth != '0;

	// an empty texture answers with all zeros
	`TMLO_ASSERT_IMP(a_empty_zero, clk, arst_n, m_axis_tvalid && stat.empty, m_axis_tdata == '0)
	// a real texture never reports a zero-sized mip
	`TMLO_ASSERT_IMP(a_dims_nonzero, clk, arst_n, m_axis_tvalid && !stat.empty, dims_nonzero)
	// one request at a time: taking a request leaves idle
	`TMLO_ASSERT_NXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

>>> tb/sv/tb_texture_mip_layout_offset_unit.sv
`timescale 1ns / 1ps

module tb_texture_mip_layout_offset_unit;
	import tmlo_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_DIR       = 22;
	localparam int N_DIR_CFG   = 10;
	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 124;

	typedef struct {
		int          cfg_id;
		logic [5:0]  mip;
		logic [15:0] layer;
		bit          fixed;
		out_t        want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b1;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [5:0] mip_index, [21:6] layer_index, [23:22] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [15:0] mip_width, [31:16] mip_height, [47:32] mip_depth,
	// [111:48] image_bytes, [175:112] mip_offset, [239:176] layer_offset,
	// [244:240] max_mips, [247:245] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow of the register file, tracked from the bus
	cfg_t        layout = '{16'd1, 16'd1, 16'd1, 16'd1, 1'b0, 5'd4, 5'd4, 5'd4};
	out_t        pending_layouts[$];
	bit          drv_fixed = 1'b0;
	out_t        drv_want = '0;
	int unsigned n_sent = 0;
	int unsigned n_results = 0;
	int unsigned n_mismatch = 0;
	int unsigned n_settings = 0;
	int unsigned idle_cycles = 0;
	bit          tx_random = 1'b1;
	bit          rx_random = 1'b1;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_roll;

	dir_row_t    dir_rows[N_DIR];
	cfg_t        dir_cfgs[N_DIR_CFG];

	texture_mip_layout_offset_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] mip_extent(logic [15:0] base, int unsigned lvl);
		logic [63:0] d;
		d = 64'(base) >> lvl;
		return (d == 64'd0) ? 64'd1 : d;
	endfunction

	function automatic logic [63:0] level_bytes(cfg_t c, int unsigned lvl);
		logic [63:0] w, h, d, bw, bh;
		w = mip_extent(c.base_width, lvl);
		h = mip_extent(c.base_height, lvl);
		d = mip_extent(c.base_depth, lvl);
		if (c.block_compressed) begin
			// a zero block size counts as one pixel
			bw = (c.block_width == 5'd0) ? 64'd1 : 64'(c.block_width);
			bh = (c.block_height == 5'd0) ? 64'd1 : 64'(c.block_height);
			return ((w + bw - 1) / bw) * ((h + bh - 1) / bh) * d * 64'(c.unit_bytes);
		end
		return w * h * d * 64'(c.unit_bytes);
	endfunction

	function automatic out_t locate_mip(cfg_t c, logic [5:0] mip, logic [15:0] layer);
		out_t        r;
		logic [63:0] img, run, widest;
		int unsigned i, n;
		r = '0;
		if (c.base_width == 0 || c.base_height == 0 || c.base_depth == 0)
			return r;
		img = level_bytes(c, mip);
		run = 64'd0;
		if (mip != 0 && c.layer_count != 0) begin
			for (i = 0; i < mip; i++)
				run += level_bytes(c, i);
			run = run * 64'(c.layer_count);
		end
		widest = 64'(c.base_width);
		if (64'(c.base_height) > widest)
			widest = 64'(c.base_height);
		if (64'(c.base_depth) > widest)
			widest = 64'(c.base_depth);
		n = 0;
		while (widest != 0) begin
			n++;
			widest >>= 1;
		end
		r.mip_width    = 16'(mip_extent(c.base_width, mip));
		r.mip_height   = 16'(mip_extent(c.base_height, mip));
		r.mip_depth    = 16'(mip_extent(c.base_depth, mip));
		r.image_bytes  = img;
		r.mip_offset   = run;
		r.layer_offset = (mip == 0 && c.layer_count == 0) ? 64'd0 : run + img * 64'(layer);
		r.max_mips     = 5'(n);
		return r;
	endfunction

	function automatic out_t mk_layout(int unsigned w, int unsigned h, int unsigned d,
			logic [63:0] img, logic [63:0] moff, logic [63:0] loff, int unsigned mips);
		out_t r;
		r = '0;
		r.mip_width    = 16'(w);
		r.mip_height   = 16'(h);
		r.mip_depth    = 16'(d);
		r.image_bytes  = img;
		r.mip_offset   = moff;
		r.layer_offset = loff;
		r.max_mips     = 5'(mips);
		return r;
	endfunction

	function automatic logic [15:0] rand_dim();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(1, 16));
			1: return 16'($urandom_range(1, 1024));
			2: return 16'($urandom_range(1, 65535));
			default: return 16'($urandom_range(32768, 65535));
		endcase
	endfunction

	function automatic cfg_t random_layout();
		cfg_t c;
		c.base_width  = rand_dim();
		c.base_height = rand_dim();
		c.base_depth  = ($urandom_range(0, 2) == 0) ? rand_dim() : 16'd1;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: c.base_width = '0;
				1: c.base_height = '0;
				default: c.base_depth = '0;
			endcase
		end
		case ($urandom_range(0, 3))
			0: c.layer_count = 16'($urandom_range(0, 1));
			1: c.layer_count = 16'($urandom_range(1, 16));
			default: c.layer_count = 16'($urandom_range(0, 65535));
		endcase
		c.block_compressed = 1'($urandom_range(0, 1));
		c.block_width  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 16));
		c.block_height = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 16));
		c.unit_bytes   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 16));
		return c;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!tx_random)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			n_mismatch++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// let every outstanding request come back, then leave the block idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (n_results != n_sent)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_cfg(cfg_t c);
		drain();
		// junk above each field checks that the block keeps only the low bits
		apb_write(REG_BASE_WIDTH,  {16'($urandom), c.base_width});
		apb_write(REG_BASE_HEIGHT, {16'($urandom), c.base_height});
		apb_write(REG_BASE_DEPTH,  {16'($urandom), c.base_depth});
		apb_write(REG_LAYER_COUNT, {16'($urandom), c.layer_count});
		apb_write(REG_BLOCK_COMP,  {31'($urandom), c.block_compressed});
		apb_write(REG_BLOCK_W,     {27'($urandom), c.block_width});
		apb_write(REG_BLOCK_H,     {27'($urandom), c.block_height});
		apb_write(REG_UNIT_BYTES,  {27'($urandom), c.unit_bytes});
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic send_query(logic [5:0] mip, logic [15:0] layer, bit fixed, out_t want,
			int unsigned gap);
		in_t q;
		q = '0;
		q.mip_index   = mip;
		q.layer_index = layer;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= q;
		drv_fixed     <= fixed;
		drv_want      <= want;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_sent++;
	endtask

	// receiver: random stalls, plus one long hold on request from the stimulus
	always @(posedge clk) begin
		if (rx_wait != 0) begin
			rx_wait       <= rx_wait - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen     <= hold_asks;
			rx_wait       <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (!rx_random) begin
			m_axis_tready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				m_axis_tready <= 1'b1;
			end else if (rx_roll < 97) begin
				m_axis_tready <= 1'b0;
				rx_wait       <= $urandom_range(0, 4);
			end else begin
				m_axis_tready <= 1'b0;
				rx_wait       <= $urandom_range(20, 120);
			end
		end
	end

	// bus monitor, predictor, scoreboard and watchdog
	always @(posedge clk) begin
		in_t  q;
		out_t want, got;
		bit   busy;
		busy = !arst_n;
		if (arst_n && psel && penable && pwrite && pready) begin
			busy = 1'b1;
			case (paddr[4:2])
				REG_BASE_WIDTH:  layout.base_width       = pwdata[15:0];
				REG_BASE_HEIGHT: layout.base_height      = pwdata[15:0];
				REG_BASE_DEPTH:  layout.base_depth       = pwdata[15:0];
				REG_LAYER_COUNT: layout.layer_count      = pwdata[15:0];
				REG_BLOCK_COMP:  layout.block_compressed = pwdata[0];
				REG_BLOCK_W:     layout.block_width      = pwdata[4:0];
				REG_BLOCK_H:     layout.block_height     = pwdata[4:0];
				REG_UNIT_BYTES:  layout.unit_bytes       = pwdata[4:0];
				default: ;
			endcase
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			busy = 1'b1;
			q = s_axis_tdata;
			pending_layouts.push_back(drv_fixed ? drv_want :
				locate_mip(layout, q.mip_index, q.layer_index));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			busy = 1'b1;
			n_results++;
			got = m_axis_tdata;
			if (pending_layouts.size() == 0) begin
				n_mismatch++;
				$display("%0t: result with no request pending, data %h", $time, got);
			end else begin
				want = pending_layouts.pop_front();
				check_field("mip_width",    64'(want.mip_width),  64'(got.mip_width));
				check_field("mip_height",   64'(want.mip_height), 64'(got.mip_height));
				check_field("mip_depth",    64'(want.mip_depth),  64'(got.mip_depth));
				check_field("image_bytes",  want.image_bytes,     got.image_bytes);
				check_field("mip_offset",   want.mip_offset,      got.mip_offset);
				check_field("layer_offset", want.layer_offset,    got.layer_offset);
				check_field("max_mips",     64'(want.max_mips),   64'(got.max_mips));
			end
		end
		idle_cycles = busy ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d requests outstanding",
				$time, IDLE_LIMIT, pending_layouts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cfg_t        c;
		int unsigned ph, k, r, cur_id, gap;
		logic [5:0]  mip;
		logic [15:0] layer;

		dir_cfgs = '{
			'{16'd1,     16'd1,     16'd1,     16'd1,     1'b0, 5'd4,  5'd4,  5'd4},
			'{16'd0,     16'd16,    16'd16,    16'd4,     1'b0, 5'd4,  5'd4,  5'd4},
			'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, 5'd4,  5'd4,  5'd16},
			'{16'd1000,  16'd600,   16'd1,     16'd6,     1'b1, 5'd4,  5'd4,  5'd8},
			'{16'd300,   16'd77,    16'd5,     16'd3,     1'b1, 5'd0,  5'd31, 5'd16},
			'{16'd64,    16'd32,    16'd8,     16'd2,     1'b0, 5'd4,  5'd4,  5'd0},
			'{16'd256,   16'd256,   16'd1,     16'd0,     1'b0, 5'd4,  5'd4,  5'd4},
			'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1, 5'd16, 5'd16, 5'd16},
			'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1, 5'd31, 5'd31, 5'd31},
			'{16'd5,     16'd7,     16'd0,     16'd9,     1'b1, 5'd4,  5'd4,  5'd8}
		};
		// cfg 0 is the state after reset and is never written
		dir_rows = '{
			'{0, 6'd0,  16'd0,     1'b1, mk_layout(1, 1, 1, 4, 0, 0, 1)},
			'{0, 6'd63, 16'd65535, 1'b0, '0},
			'{0, 6'd5,  16'd1,     1'b0, '0},
			'{1, 6'd0,  16'd0,     1'b1, '0},
			'{1, 6'd63, 16'd65535, 1'b1, '0},
			'{2, 6'd0,  16'd65535, 1'b0, '0},
			'{2, 6'd1,  16'd0,     1'b0, '0},
			'{2, 6'd63, 16'd65535, 1'b0, '0},
			'{3, 6'd0,  16'd0,     1'b0, '0},
			'{3, 6'd4,  16'd5,     1'b0, '0},
			'{3, 6'd10, 16'd65535, 1'b0, '0},
			'{4, 6'd0,  16'd1,     1'b0, '0},
			'{4, 6'd6,  16'd2,     1'b0, '0},
			'{5, 6'd2,  16'd1,     1'b1, mk_layout(16, 8, 2, 0, 0, 0, 7)},
			'{5, 6'd0,  16'd65535, 1'b1, mk_layout(64, 32, 8, 0, 0, 0, 7)},
			'{6, 6'd0,  16'd5,     1'b1, mk_layout(256, 256, 1, 262144, 0, 0, 9)},
			'{6, 6'd3,  16'd7,     1'b1, mk_layout(32, 32, 1, 4096, 0, 28672, 9)},
			'{7, 6'd63, 16'd65535, 1'b0, '0},
			'{7, 6'd16, 16'd32768, 1'b0, '0},
			'{8, 6'd63, 16'd65535, 1'b0, '0},
			'{8, 6'd1,  16'd42,    1'b0, '0},
			'{9, 6'd3,  16'd3,     1'b1, '0}
		};

		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_id = 0;
		for (k = 0; k < N_DIR; k++) begin
			if (dir_rows[k].cfg_id != cur_id) begin
				apply_cfg(dir_cfgs[dir_rows[k].cfg_id]);
				cur_id = dir_rows[k].cfg_id;
			end
			send_query(dir_rows[k].mip, dir_rows[k].layer, dir_rows[k].fixed,
				dir_rows[k].want, pick_gap());
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				3: c = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, 5'd1, 5'd1, 5'd31};
				7: c = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1, 5'd1, 5'd1, 5'd16};
				default: c = random_layout();
			endcase
			apply_cfg(c);
			tx_random = (ph % 3 != 0);
			rx_random = (ph % 4 != 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				mip = (r < 80) ? 6'($urandom_range(0, 7)) :
					(r < 96) ? 6'($urandom_range(0, 20)) : 6'($urandom_range(0, 63));
				r = $urandom_range(0, 99);
				layer = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(0, 65535));
				// phase 5: stall the result side for a long stretch and keep pushing
				if (ph == 5 && k == 10)
					hold_asks++;
				gap = (ph == 5 && k >= 10 && k < 30) ? 0 : pick_gap();
				send_query(mip, layer, 1'b0, '0, gap);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d queries over %0d register settings, %0d results checked",
			n_sent, n_settings, n_results);
		$display("edge cases: empty base, zero layers, odd blocks, no format; %0d mismatches",
			n_mismatch);
		if (n_mismatch == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
